FILE: sv/im2c_pkg.sv
// ----------------------------------------------------------------------------
// im2c_pkg
// Shared types and constants of the im2col address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package im2c_pkg;

  // largest kernel side, image side and stride honored by the clamps
  localparam int MAX_KERNEL = 8;
  localparam int MAX_DIM    = 4096;
  localparam int MAX_STRIDE = 8;

  // field widths
  localparam int DIM_W   = 13;
  localparam int KER_W   = 4;
  localparam int PAD_W   = 3;
  localparam int STR_W   = 4;
  localparam int GRID_W  = 14;
  localparam int IDX_W   = 34;
  localparam int DST_W   = 40;
  localparam int TAP_W   = 3;
  localparam int CFG_W   = 13;
  localparam int CFGA_W  = 3;
  localparam int COORD_W = 15;

  // configuration register indexes
  typedef enum logic [CFGA_W-1:0] {
    REG_IMAGE_HEIGHT = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_KERNEL_ROWS  = 3'd2,
    REG_KERNEL_COLS  = 3'd3,
    REG_PAD_ROWS     = 3'd4,
    REG_PAD_COLS     = 3'd5,
    REG_STRIDE_ROWS  = 3'd6,
    REG_STRIDE_COLS  = 3'd7
  } cfg_reg_t;

  // operand selection of the shared divider
  typedef enum logic [1:0] {
    DIV_GRID_ROWS,
    DIV_GRID_COLS,
    DIV_POS_COL,
    DIV_POS_ROW
  } div_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROWS_GO,
    S_ROWS_WAIT,
    S_COLS_GO,
    S_COLS_WAIT,
    S_PLANE,
    S_COL_GO,
    S_COL_WAIT,
    S_ROW_GO,
    S_ROW_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_LOAD,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     plane_ld;
    logic     pos_ld;
    logic     mul_a;
    logic     mul_b;
    logic     mul_c;
    logic     tap_init;
    logic     tap_adv;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last;
  } dp_stat_t;

endpackage

FILE: sv/im2c_div.sv
// ----------------------------------------------------------------------------
// im2c_div
// Restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module im2c_div import im2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IDX_W-1:0]  dividend,
  input  logic [GRID_W-1:0] divisor,
  output logic [IDX_W-1:0]  quotient,
  output logic [GRID_W-1:0] remainder,
  output logic              done
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0]  quo_r, quo_nxt;
  logic [GRID_W-1:0] rem_r, rem_nxt;
  logic [GRID_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [GRID_W:0]   trial;

  // one shift and subtract step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[IDX_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(IDX_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = GRID_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[IDX_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[GRID_W-1:0];
        quo_nxt = {quo_r[IDX_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

FILE: sv/im2c_ctrl.sv
// ----------------------------------------------------------------------------
// im2c_ctrl
// Sequencer: grid setup after configuration, position split, tap walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module im2c_ctrl import im2c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     cfg_we,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   dirty_r, dirty_nxt;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = (state_r == S_IDLE) && !dirty_r && in_valid;
  assign out_acc = (state_r == S_EMIT) && !out_stall;

  // grid sizes need recomputing after any register write
  always_comb begin
    dirty_nxt = dirty_r;
    if (state_r == S_ROWS_GO) dirty_nxt = 1'b0;
    if (cfg_we) dirty_nxt = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (dirty_r) state_nxt = S_ROWS_GO;
        else if (in_valid) state_nxt = S_COL_GO;
      end
      S_ROWS_GO:   state_nxt = S_ROWS_WAIT;
      S_ROWS_WAIT: if (stat.div_done) state_nxt = S_COLS_GO;
      S_COLS_GO:   state_nxt = S_COLS_WAIT;
      S_COLS_WAIT: if (stat.div_done) state_nxt = S_PLANE;
      S_PLANE:     state_nxt = S_IDLE;
      S_COL_GO:    state_nxt = S_COL_WAIT;
      S_COL_WAIT:  if (stat.div_done) state_nxt = S_ROW_GO;
      S_ROW_GO:    state_nxt = S_ROW_WAIT;
      S_ROW_WAIT:  if (stat.div_done) state_nxt = S_MUL_A;
      S_MUL_A:     state_nxt = S_MUL_B;
      S_MUL_B:     state_nxt = S_MUL_C;
      S_MUL_C:     state_nxt = S_LOAD;
      S_LOAD:      state_nxt = S_EMIT;
      S_EMIT:      if (out_acc && stat.last) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_GRID_ROWS;
    case (state_r)
      S_IDLE:      cmd.pos_ld = in_acc;
      S_ROWS_GO:   cmd.div_start = 1'b1;
      S_ROWS_WAIT: cmd.div_capture = stat.div_done;
      S_COLS_GO: begin
        cmd.div_sel   = DIV_GRID_COLS;
        cmd.div_start = 1'b1;
      end
      S_COLS_WAIT: begin
        cmd.div_sel     = DIV_GRID_COLS;
        cmd.div_capture = stat.div_done;
      end
      S_PLANE:     cmd.plane_ld = 1'b1;
      S_COL_GO: begin
        cmd.div_sel   = DIV_POS_COL;
        cmd.div_start = 1'b1;
      end
      S_COL_WAIT: begin
        cmd.div_sel     = DIV_POS_COL;
        cmd.div_capture = stat.div_done;
      end
      S_ROW_GO: begin
        cmd.div_sel   = DIV_POS_ROW;
        cmd.div_start = 1'b1;
      end
      S_ROW_WAIT: begin
        cmd.div_sel     = DIV_POS_ROW;
        cmd.div_capture = stat.div_done;
      end
      S_MUL_A:     cmd.mul_a = 1'b1;
      S_MUL_B:     cmd.mul_b = 1'b1;
      S_MUL_C:     cmd.mul_c = 1'b1;
      S_LOAD:      cmd.tap_init = 1'b1;
      S_EMIT:      cmd.tap_adv = out_acc;
      default:     cmd = '0;
    endcase
  end

  // state registers, grid setup runs after reset too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  assign in_stall  = !((state_r == S_IDLE) && !dirty_r);
  assign out_valid = (state_r == S_EMIT);

endmodule

FILE: sv/im2c_dp.sv
// ----------------------------------------------------------------------------
// im2c_dp
// Datapath: configuration, grid sizes, position split, address arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module im2c_dp import im2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [IDX_W-1:0]  in_position_index,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [IDX_W-1:0]  out_src_index,
  output logic [DST_W-1:0]  out_dst_index,
  output logic              out_zero_fill,
  output logic              out_last_tap
);

  // configuration registers
  logic [DIM_W-1:0] img_h_r, img_w_r;
  logic [KER_W-1:0] ker_r_r, ker_c_r;
  logic [PAD_W-1:0] pad_r_r, pad_c_r;
  logic [STR_W-1:0] str_r_r, str_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_h_r <= DIM_W'(1);
      img_w_r <= DIM_W'(1);
      ker_r_r <= KER_W'(1);
      ker_c_r <= KER_W'(1);
      pad_r_r <= '0;
      pad_c_r <= '0;
      str_r_r <= STR_W'(1);
      str_c_r <= STR_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_HEIGHT: img_h_r <= cfg_data[DIM_W-1:0];
        REG_IMAGE_WIDTH:  img_w_r <= cfg_data[DIM_W-1:0];
        REG_KERNEL_ROWS:  ker_r_r <= cfg_data[KER_W-1:0];
        REG_KERNEL_COLS:  ker_c_r <= cfg_data[KER_W-1:0];
        REG_PAD_ROWS:     pad_r_r <= cfg_data[PAD_W-1:0];
        REG_PAD_COLS:     pad_c_r <= cfg_data[PAD_W-1:0];
        REG_STRIDE_ROWS:  str_r_r <= cfg_data[STR_W-1:0];
        REG_STRIDE_COLS:  str_c_r <= cfg_data[STR_W-1:0];
        default:          img_h_r <= img_h_r;
      endcase
    end
  end

  // effective sizes: zero reads as one, oversize clamps
  logic [DIM_W-1:0] h_eff, w_eff;
  logic [KER_W-1:0] kr_eff, kc_eff, sr_eff, sc_eff;

  always_comb begin
    h_eff = img_h_r;
    if (img_h_r == '0) h_eff = DIM_W'(1);
    else if (32'(img_h_r) > 32'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
    w_eff = img_w_r;
    if (img_w_r == '0) w_eff = DIM_W'(1);
    else if (32'(img_w_r) > 32'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
    kr_eff = ker_r_r;
    if (ker_r_r == '0) kr_eff = KER_W'(1);
    else if (ker_r_r > KER_W'(MAX_KERNEL)) kr_eff = KER_W'(MAX_KERNEL);
    kc_eff = ker_c_r;
    if (ker_c_r == '0) kc_eff = KER_W'(1);
    else if (ker_c_r > KER_W'(MAX_KERNEL)) kc_eff = KER_W'(MAX_KERNEL);
    sr_eff = str_r_r;
    if (str_r_r == '0) sr_eff = KER_W'(1);
    else if (str_r_r > KER_W'(MAX_STRIDE)) sr_eff = KER_W'(MAX_STRIDE);
    sc_eff = str_c_r;
    if (str_c_r == '0) sc_eff = KER_W'(1);
    else if (str_c_r > KER_W'(MAX_STRIDE)) sc_eff = KER_W'(MAX_STRIDE);
  end

  // padded span minus kernel, floored at zero so a short span gives one
  logic [GRID_W-1:0] span_r, span_c, num_r, num_c;

  always_comb begin
    span_r = GRID_W'(h_eff) + GRID_W'({pad_r_r, 1'b0});
    span_c = GRID_W'(w_eff) + GRID_W'({pad_c_r, 1'b0});
    num_r  = (span_r >= GRID_W'(kr_eff)) ? span_r - GRID_W'(kr_eff) : '0;
    num_c  = (span_c >= GRID_W'(kc_eff)) ? span_c - GRID_W'(kc_eff) : '0;
  end

  // shared divider
  logic [IDX_W-1:0]  div_a, div_q;
  logic [GRID_W-1:0] div_b, div_rem;
  logic              div_done;

  logic [IDX_W-1:0]  idx_r, rest_r, chan_r;
  logic [GRID_W-1:0] orows_r, ocols_r, out_row_r, out_col_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_GRID_ROWS: begin
        div_a = IDX_W'(num_r);
        div_b = GRID_W'(sr_eff);
      end
      DIV_GRID_COLS: begin
        div_a = IDX_W'(num_c);
        div_b = GRID_W'(sc_eff);
      end
      DIV_POS_COL: begin
        div_a = idx_r;
        div_b = ocols_r;
      end
      DIV_POS_ROW: begin
        div_a = rest_r;
        div_b = orows_r;
      end
      default: begin
        div_a = idx_r;
        div_b = ocols_r;
      end
    endcase
  end

  im2c_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_rem),
    .done      (div_done)
  );

  // datapath registers
  logic [27:0]            plane_r, plane_nxt;
  logic [6:0]             kk_r, kk_nxt;
  logic [IDX_W-1:0]       idx_nxt, rest_nxt, chan_nxt;
  logic [GRID_W-1:0]      orows_nxt, ocols_nxt, out_row_nxt, out_col_nxt;
  logic [COORD_W-1:0]     row0_r, row0_nxt, col0_r, col0_nxt;
  logic [IDX_W-1:0]       chanh_r, chanh_nxt, rowaddr_r, rowaddr_nxt;
  logic [DST_W-1:0]       chkk_r, chkk_nxt, d1_r, d1_nxt, d2_r, d2_nxt;
  logic [DST_W-1:0]       dst_r, dst_nxt;
  logic [TAP_W-1:0]       tap_i_r, tap_i_nxt, tap_j_r, tap_j_nxt;
  logic [17:0]            row_prod, col_prod;
  logic                   last;

  assign row_prod = 18'(out_row_r) * 18'(sr_eff);
  assign col_prod = 18'(out_col_r) * 18'(sc_eff);
  assign last = ({1'b0, tap_i_r} == kr_eff - 1'b1) && ({1'b0, tap_j_r} == kc_eff - 1'b1);

  always_comb begin
    orows_nxt   = orows_r;
    ocols_nxt   = ocols_r;
    plane_nxt   = plane_r;
    kk_nxt      = kk_r;
    idx_nxt     = idx_r;
    rest_nxt    = rest_r;
    chan_nxt    = chan_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    row0_nxt    = row0_r;
    col0_nxt    = col0_r;
    chanh_nxt   = chanh_r;
    chkk_nxt    = chkk_r;
    rowaddr_nxt = rowaddr_r;
    d1_nxt      = d1_r;
    d2_nxt      = d2_r;
    dst_nxt     = dst_r;
    tap_i_nxt   = tap_i_r;
    tap_j_nxt   = tap_j_r;

    // divider results
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        DIV_GRID_ROWS: orows_nxt = GRID_W'(div_q) + GRID_W'(1);
        DIV_GRID_COLS: ocols_nxt = GRID_W'(div_q) + GRID_W'(1);
        DIV_POS_COL: begin
          out_col_nxt = div_rem;
          rest_nxt    = div_q;
        end
        DIV_POS_ROW: begin
          out_row_nxt = div_rem;
          chan_nxt    = div_q;
        end
        default: rest_nxt = rest_r;
      endcase
    end

    // per-configuration products
    if (cmd.plane_ld) begin
      plane_nxt = 28'(orows_r) * 28'(ocols_r);
      kk_nxt    = 7'(kr_eff) * 7'(kc_eff);
    end

    if (cmd.pos_ld) idx_nxt = in_position_index;

    // placement origin and first products
    if (cmd.mul_a) begin
      row0_nxt  = COORD_W'(row_prod) - COORD_W'(pad_r_r);
      col0_nxt  = COORD_W'(col_prod) - COORD_W'(pad_c_r);
      chanh_nxt = chan_r * IDX_W'(h_eff);
      chkk_nxt  = DST_W'(chan_r) * DST_W'(kk_r);
    end

    // first image row address and destination partial
    if (cmd.mul_b) begin
      rowaddr_nxt = (chanh_r + {{(IDX_W-COORD_W){row0_r[COORD_W-1]}}, row0_r})
                    * IDX_W'(w_eff);
      d1_nxt      = chkk_r * DST_W'(orows_r);
    end

    if (cmd.mul_c) d2_nxt = (d1_r + DST_W'(out_row_r)) * DST_W'(ocols_r);

    if (cmd.tap_init) begin
      dst_nxt   = d2_r + DST_W'(out_col_r);
      tap_i_nxt = '0;
      tap_j_nxt = '0;
    end

    // tap walk, row-major
    if (cmd.tap_adv) begin
      dst_nxt = dst_r + DST_W'(plane_r);
      if ({1'b0, tap_j_r} == kc_eff - 1'b1) begin
        tap_j_nxt   = '0;
        tap_i_nxt   = tap_i_r + 1'b1;
        rowaddr_nxt = rowaddr_r + IDX_W'(w_eff);
      end else begin
        tap_j_nxt = tap_j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    orows_r   <= orows_nxt;
    ocols_r   <= ocols_nxt;
    plane_r   <= plane_nxt;
    kk_r      <= kk_nxt;
    idx_r     <= idx_nxt;
    rest_r    <= rest_nxt;
    chan_r    <= chan_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
    row0_r    <= row0_nxt;
    col0_r    <= col0_nxt;
    chanh_r   <= chanh_nxt;
    chkk_r    <= chkk_nxt;
    rowaddr_r <= rowaddr_nxt;
    d1_r      <= d1_nxt;
    d2_r      <= d2_nxt;
    dst_r     <= dst_nxt;
    tap_i_r   <= tap_i_nxt;
    tap_j_r   <= tap_j_nxt;
  end

  // tap coordinates, padding test and source address
  logic [COORD_W-1:0] tr, tc;
  logic               pad;

  always_comb begin
    tr  = row0_r + COORD_W'(tap_i_r);
    tc  = col0_r + COORD_W'(tap_j_r);
    pad = tr[COORD_W-1] || tc[COORD_W-1] ||
          (tr >= COORD_W'(h_eff)) || (tc >= COORD_W'(w_eff));
    out_src_index = pad ? '0 :
      rowaddr_r + {{(IDX_W-COORD_W){col0_r[COORD_W-1]}}, col0_r} + IDX_W'(tap_j_r);
  end

  assign out_dst_index = dst_r;
  assign out_zero_fill = pad;
  assign out_last_tap  = last;
  assign stat.div_done = div_done;
  assign stat.last     = last;

endmodule

FILE: sv/im2col_address_generator.sv
// ----------------------------------------------------------------------------
// im2col_address_generator
// Turns placement indexes into per-tap image and column-buffer addresses.
// ----------------------------------------------------------------------------
// Each accepted position index yields kernel_rows*kernel_cols items, one per
// cycle while out_stall is low, in row-major tap order. Before the first tap
// is offered, the index is split into column, row and channel through one
// shared divider that resolves a quotient bit per cycle (two 34-bit
// divisions), then passes through three multiply steps and one load step.
// After reset and after any configuration write, the first item also waits
// while the same divider derives the output grid size. One item is in work
// at a time.
`timescale 1ns / 1ps

module im2col_address_generator import im2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [IDX_W-1:0]  in_position_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_src_index,
  output logic [DST_W-1:0]  out_dst_index,
  output logic              out_zero_fill,
  output logic              out_last_tap,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  im2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  // address arithmetic
  im2c_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_position_index (in_position_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_src_index     (out_src_index),
    .out_dst_index     (out_dst_index),
    .out_zero_fill     (out_zero_fill),
    .out_last_tap      (out_last_tap)
  );

endmodule

FILE: tb/im2col_address_generator_tb.sv
// ----------------------------------------------------------------------------
// im2col_address_generator_tb
// Self-checking bench for the im2col address generator: a directed table
// and random position indexes run under a series of configurations, every
// emitted tap is checked against the table or a local model of the unfold arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module im2col_address_generator_tb;
  import im2c_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic             zero_fill;
    logic             last_tap;
  } tap_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    bit               typed;
    logic [IDX_W-1:0] src;
    logic [DST_W-1:0] dst;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [IDX_W-1:0]  in_position_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_src_index;
  logic [DST_W-1:0]  out_dst_index;
  logic              out_zero_fill;
  logic              out_last_tap;
  logic              cfg_we = 1'b0;
  logic [CFGA_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // shadow of the configuration registers, at register widths
  logic [DIM_W-1:0] sh_height = 1, sh_width = 1;
  logic [KER_W-1:0] sh_krows = 1, sh_kcols = 1;
  logic [PAD_W-1:0] sh_prows = 0, sh_pcols = 0;
  logic [STR_W-1:0] sh_srows = 1, sh_scols = 1;

  tap_t pending_taps[$];
  int   fail_count = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  im2col_address_generator dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic longint unsigned clamp_reg(input longint unsigned v,
                                                input longint unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic longint unsigned grid_size(input longint unsigned dim, pad, k, s);
    longint unsigned span;
    span = dim + 2 * pad;
    if (span < k) return 1;
    return (span - k) / s + 1;
  endfunction

  // expected taps of one placement, appended to the pending queue
  task automatic unfold_taps(input logic [IDX_W-1:0] index);
    longint unsigned h, w, kr, kc, sr, sc, orows, ocols, ocol, orow, chan, dst;
    longint r0, c0, r, c;
    tap_t t;
    h = clamp_reg(sh_height, MAX_DIM);
    w = clamp_reg(sh_width, MAX_DIM);
    kr = clamp_reg(sh_krows, MAX_KERNEL);
    kc = clamp_reg(sh_kcols, MAX_KERNEL);
    sr = clamp_reg(sh_srows, MAX_STRIDE);
    sc = clamp_reg(sh_scols, MAX_STRIDE);
    orows = grid_size(h, sh_prows, kr, sr);
    ocols = grid_size(w, sh_pcols, kc, sc);
    ocol = index % ocols;
    orow = (index / ocols) % orows;
    chan = (index / ocols) / orows;
    r0 = longint'(orow * sr) - longint'(sh_prows);
    c0 = longint'(ocol * sc) - longint'(sh_pcols);
    dst = ((chan * kr * kc) * orows + orow) * ocols + ocol;
    for (longint unsigned i = 0; i < kr; i++) begin
      for (longint unsigned j = 0; j < kc; j++) begin
        r = r0 + longint'(i);
        c = c0 + longint'(j);
        t.zero_fill = (r < 0 || c < 0 || r >= longint'(h) || c >= longint'(w));
        t.src = t.zero_fill ? '0 : IDX_W'((chan * h + r) * w + c);
        t.dst = DST_W'(dst);
        t.last_tap = (i + 1 == kr && j + 1 == kc);
        pending_taps.push_back(t);
        dst += orows * ocols;
      end
    end
  endtask

  // register write at falling edges, shadow follows
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_IMAGE_HEIGHT: sh_height = value[DIM_W-1:0];
      REG_IMAGE_WIDTH:  sh_width = value[DIM_W-1:0];
      REG_KERNEL_ROWS:  sh_krows = value[KER_W-1:0];
      REG_KERNEL_COLS:  sh_kcols = value[KER_W-1:0];
      REG_PAD_ROWS:     sh_prows = value[PAD_W-1:0];
      REG_PAD_COLS:     sh_pcols = value[PAD_W-1:0];
      REG_STRIDE_ROWS:  sh_srows = value[STR_W-1:0];
      default:          sh_scols = value[STR_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] h, w, kr, kc, pr, pc, sr, sc);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_KERNEL_ROWS, kr);
    write_reg(REG_KERNEL_COLS, kc);
    write_reg(REG_PAD_ROWS, pr);
    write_reg(REG_PAD_COLS, pc);
    write_reg(REG_STRIDE_ROWS, sr);
    write_reg(REG_STRIDE_COLS, sc);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait until every expected tap has arrived, then settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_taps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // offer one item; called and returns at a falling edge
  task automatic send_item(input stim_row_t row);
    int gap;
    tap_t t;
    gap = (!quiet && $urandom_range(99) < 27) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_position_index <= row.index;
    do @(posedge clk); while (in_stall);
    if (row.typed) begin
      t.src = row.src;
      t.dst = row.dst;
      t.zero_fill = 1'b0;
      t.last_tap = 1'b1;
      pending_taps.push_back(t);
    end else begin
      unfold_taps(row.index);
    end
    @(negedge clk);
  endtask

  task automatic send_index(input logic [IDX_W-1:0] index);
    stim_row_t row;
    row.index = index;
    row.typed = 1'b0;
    send_item(row);
  endtask

  // index mostly inside a small launch, sometimes anywhere in the field
  function automatic logic [IDX_W-1:0] pick_index;
    longint unsigned plane;
    if ($urandom_range(99) < 20) return IDX_W'({$urandom, $urandom});
    plane = grid_size(clamp_reg(sh_height, MAX_DIM), sh_prows,
                      clamp_reg(sh_krows, MAX_KERNEL), clamp_reg(sh_srows, MAX_STRIDE))
          * grid_size(clamp_reg(sh_width, MAX_DIM), sh_pcols,
                      clamp_reg(sh_kcols, MAX_KERNEL), clamp_reg(sh_scols, MAX_STRIDE));
    return IDX_W'(longint'($urandom_range(3)) * plane + $urandom % plane);
  endfunction

  // receiver stall, with a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 27);
    end
  end

  // result checker
  always @(posedge clk) begin
    tap_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_taps.size() == 0) begin
        report_mismatch("unexpected tap");
      end else begin
        e = pending_taps.pop_front();
        if (out_src_index !== e.src)
          report_mismatch($sformatf("src_index %h exp %h", out_src_index, e.src));
        if (out_dst_index !== e.dst)
          report_mismatch($sformatf("dst_index %h exp %h", out_dst_index, e.dst));
        if (out_zero_fill !== e.zero_fill)
          report_mismatch($sformatf("zero_fill %b exp %b", out_zero_fill, e.zero_fill));
        if (out_last_tap !== e.last_tap)
          report_mismatch($sformatf("last_tap %b exp %b", out_last_tap, e.last_tap));
      end
    end
  end

  initial begin
    stim_row_t table_rows[$];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: one tap per item, both addresses equal the index
    table_rows = '{
      '{34'h0,         1, 34'h0,         40'h0},
      '{34'h1,         1, 34'h1,         40'h1},
      '{34'h3FFFFFFFF, 1, 34'h3FFFFFFFF, 40'h3FFFFFFFF},
      '{34'h2AAAAAAAA, 1, 34'h2AAAAAAAA, 40'h2AAAAAAAA},
      '{34'h155555555, 1, 34'h155555555, 40'h155555555}
    };
    foreach (table_rows[k]) send_item(table_rows[k]);
    drain();

    // 3x3 with padding; receiver holds off while items keep coming
    set_geometry(8, 8, 3, 3, 1, 1, 1, 1);
    hold_req = 1'b1;
    table_rows = '{
      '{34'd0,  0, 0, 0}, '{34'd7,  0, 0, 0}, '{34'd63, 0, 0, 0},
      '{34'd64, 0, 0, 0}, '{34'h3FFFFFFFF, 0, 0, 0}, '{34'd27, 0, 0, 0}
    };
    foreach (table_rows[k]) send_item(table_rows[k]);
    drain();

    // largest values: height and kernel rows beyond their clamps, width and kernel columns at them, max pad and stride
    set_geometry(13'h1FFF, 4096, 15, 8, 7, 7, 8, 8);
    send_index(0);
    send_index(34'h3FFFFFFFF);
    drain();

    // zero sizes and strides read as one
    set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
    send_index(34'd5);
    send_index(34'h3FFFFFFFF);
    drain();

    // kernel larger than the padded image
    set_geometry(2, 3, 8, 7, 0, 1, 15, 9);
    send_index(0);
    send_index(34'd9);
    drain();

    // uneven geometry with strides above one
    set_geometry(13, 9, 5, 2, 2, 3, 2, 3);
    send_index(0);
    send_index(34'd30);
    send_index(34'h2AAAAAAAA);
    drain();

    // random geometries, mostly small; one phase without idling
    for (int phase = 0; phase < 10; phase++) begin
      quiet = (phase == 3);
      if ($urandom_range(9) == 0)
        set_geometry(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                     CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                     CFG_W'($urandom), CFG_W'($urandom));
      else
        set_geometry(CFG_W'($urandom_range(24)), CFG_W'($urandom_range(24)),
                     CFG_W'($urandom_range(5)), CFG_W'($urandom_range(5)),
                     CFG_W'($urandom_range(7)), CFG_W'($urandom_range(7)),
                     CFG_W'($urandom_range(4)), CFG_W'($urandom_range(4)));
      for (int n = 0; n < 15; n++) send_index(pick_index());
      if (phase == 6) begin
        in_valid <= 1'b0;
        drain();
      end
      in_valid <= 1'b0;
      drain();
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/im2c_pkg.sv
sv/im2c_div.sv
sv/im2c_ctrl.sv
sv/im2c_dp.sv
sv/im2col_address_generator.sv
tb/im2col_address_generator_tb.sv
